### hw/rtl/b64e_pkg.sv
// Shared types, constants and the character mapping of the Base64 encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package b64e_pkg;

   localparam logic [7:0] PadChar   = 8'h3D;   // '='
   localparam int         QueueDepth = 4;
   localparam int         QueuePtrW  = $clog2(QueueDepth);
   localparam int         QueueCntW  = $clog2(QueueDepth + 1);
   localparam int         JobChars   = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_type;

   // One byte's worth of output: up to four characters, last_idx is count minus one.
   typedef struct packed {
      logic [JobChars-1:0][7:0] chars;
      logic [1:0]               last_idx;
      logic                     ends_msg;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

### hw/rtl/b64e_front.sv
// Front end of the Base64 encoder: accepts bytes, tracks the group phase and
// leftover bits, and turns each byte into a job of characters. Uses b64e_pkg.
`timescale 1ns / 1ps

module b64e_front
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_payload,
   input  q_status_type q_status,
   output logic         push,
   output job_type      push_job
);

   typedef enum logic [1:0] {
      PH0 = 2'd0,
      PH1 = 2'd1,
      PH2 = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       accept;
   logic [7:0] b;
   logic       fin;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;
   assign b         = req_payload.data_byte;
   assign fin       = req_payload.final_byte;

   always_comb begin
      push_job          = '0;
      push_job.ends_msg = fin;
      phase_in          = PH0;
      carry_in          = 4'd0;
      unique case (phase_ff)
         PH1: begin
            push_job.chars[0] = sextet_char({carry_ff[1:0], b[7:4]});
            if (fin) begin
               push_job.chars[1] = sextet_char({b[3:0], 2'b00});
               push_job.chars[2] = PadChar;
               push_job.last_idx = 2'd2;
            end else begin
               phase_in = PH2;
               carry_in = b[3:0];
            end
         end
         PH2: begin
            push_job.chars[0] = sextet_char({carry_ff, b[7:6]});
            push_job.chars[1] = sextet_char(b[5:0]);
            push_job.last_idx = 2'd1;
         end
         default: begin
            // The unused phase code behaves as the start of a group.
            push_job.chars[0] = sextet_char(b[7:2]);
            if (fin) begin
               push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
               push_job.chars[2] = PadChar;
               push_job.chars[3] = PadChar;
               push_job.last_idx = 2'd3;
            end else begin
               phase_in = PH1;
               carry_in = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH0;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

### hw/rtl/b64e_queue.sv
// Short job queue between the front and back ends of the Base64 encoder.
// Flip-flop storage, first in first out. Uses b64e_pkg.
`timescale 1ns / 1ps

module b64e_queue
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type q_status
);

   job_type                store_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff;
   logic                   do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### hw/rtl/b64e_back.sv
// Back end of the Base64 encoder: walks the characters of the head job and
// presents them one beat at a time from an output register. Uses b64e_pkg.
`timescale 1ns / 1ps

module b64e_back
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      head_job,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       at_end;

   assign load   = (!valid_ff || !rsp_stall) && !q_status.empty;
   assign at_end = (idx_ff == head_job.last_idx);
   assign pop    = load && at_end;
   assign idx_in = at_end ? 2'd0 : idx_ff + 2'd1;

   always_comb begin
      rsp_in.out_char = head_job.chars[idx_ff];
      rsp_in.out_last = head_job.ends_msg && at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/base64_encoder.sv
// Streaming Base64 encoder: one message byte in per beat, one ASCII character out per beat.
// Each byte's characters pass first through the job queue and then through the output register.
// Throughput: bytes are taken every cycle while the four-entry job queue has room; characters
// leave at one per cycle while the receiver does not stall, so a long message settles at four
// characters per three bytes. Reset is synchronous, active high.
// Reset empties the queue and restarts the group phase. Depends on b64e_pkg and the b64e_ parts.
`timescale 1ns / 1ps

module base64_encoder
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // The front end classifies each incoming beat by its position in the three-byte group
   // and builds the whole set of characters it produces, padding included.
   job_type      push_job, head_job;
   logic         push, pop;
   q_status_type q_status;

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   // The queue decouples the two sides, so the front keeps taking bytes while the back
   // end is stalled or busy emitting the up to four characters of an earlier byte.
   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // The back end walks the head job a character per beat through its output register.
   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // After reset nothing is offered on the result side.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // An accepted byte always leaves a job in the queue for the back end.
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_status.empty)
      else $error("accepted byte did not reach the job queue");

   // With no job waiting and no character held, nothing can appear next cycle.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared without a job");

endmodule

### dv/b64e_checker.sv
// Checker for the Base64 encoder: watches both channels, predicts the character stream
// and compares it beat by beat. Depends on b64e_pkg for the payload types and the pad code.
`timescale 1ns / 1ps

module b64e_checker
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      chars_owed
);

   // Index 0 is the leftmost character of the literal, so SYMBOLS[v] is the code for sextet v.
   localparam logic [0:63][7:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [1:0] grp_phase;
   logic [3:0] left_bits;
   rsp_type    char_queue [$];
   rsp_type    want;
   int         mismatches;

   task automatic push_char(input logic [7:0] ch, input logic last);
      rsp_type item;
      item.out_char = ch;
      item.out_last = last;
      char_queue.push_back(item);
   endtask

   // Works out the characters that one accepted byte releases and advances the group state.
   task automatic encode_byte(input req_type r);
      logic [7:0] b;
      logic       fin;
      b   = r.data_byte;
      fin = r.final_byte;
      case (grp_phase)
         2'd1: begin
            push_char(SYMBOLS[{left_bits[1:0], b[7:4]}], 1'b0);
            if (fin) begin
               push_char(SYMBOLS[{b[3:0], 2'b00}], 1'b0);
               push_char(PadChar, 1'b1);
               grp_phase = 2'd0;
               left_bits = 4'd0;
            end else begin
               grp_phase = 2'd2;
               left_bits = b[3:0];
            end
         end
         2'd2: begin
            push_char(SYMBOLS[{left_bits, b[7:6]}], 1'b0);
            push_char(SYMBOLS[b[5:0]], fin);
            grp_phase = 2'd0;
            left_bits = 4'd0;
         end
         default: begin
            push_char(SYMBOLS[b[7:2]], 1'b0);
            if (fin) begin
               push_char(SYMBOLS[{b[1:0], 4'b0000}], 1'b0);
               push_char(PadChar, 1'b0);
               push_char(PadChar, 1'b1);
               grp_phase = 2'd0;
               left_bits = 4'd0;
            end else begin
               grp_phase = 2'd1;
               left_bits = {2'b00, b[1:0]};
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         grp_phase = 2'd0;
         left_bits = 4'd0;
         char_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            if (char_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected character beat %h last %b", $realtime,
                           rsp_payload.out_char, rsp_payload.out_last);
               end
            end else begin
               want = char_queue.pop_front();
               if (rsp_payload.out_char !== want.out_char ||
                   rsp_payload.out_last !== want.out_last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: character beat mismatch: expected %h last %b, got %h last %b",
                              $realtime, want.out_char, want.out_last,
                              rsp_payload.out_char, rsp_payload.out_last);
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      chars_owed <= char_queue.size();
   end

endmodule

### dv/tb_base64_encoder.sv
// Top level of the Base64 encoder testbench: clock, reset, byte stimulus and the verdict.
// Depends on b64e_pkg, the base64_encoder block and the b64e_checker module.
`timescale 1ns / 1ps

module tb_base64_encoder
   import b64e_pkg::*;
();

   // Every input of the block holds a known value from time zero onwards.
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_stall   = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_payload;

   int fail_count;
   int chars_owed;
   int bytes_sent     = 0;
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;

   // A short directed set of messages, each entry being {data byte, final flag}. It covers a
   // lone byte of all zeros and of all ones (two characters and double padding), two-byte
   // messages (single padding), whole groups of zeros and of ones (the slash), a group made
   // only of the plus sign, a known six-byte vector, and a four-byte message that crosses a
   // group boundary before ending.
   localparam logic [0:24][8:0] DIRECTED = {
      {8'h00, 1'b1},
      {8'hFF, 1'b1},
      {8'h00, 1'b0}, {8'hFF, 1'b1},
      {8'hFF, 1'b0}, {8'h00, 1'b1},
      {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
      {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
      {8'hFB, 1'b0}, {8'hEF, 1'b0}, {8'hBE, 1'b1},
      {8'h14, 1'b0}, {8'hFB, 1'b0}, {8'h9C, 1'b0},
      {8'h03, 1'b0}, {8'hD9, 1'b0}, {8'h7E, 1'b1},
      {8'h01, 1'b0}, {8'h02, 1'b0}, {8'h03, 1'b0}, {8'h04, 1'b1}
   };

   always #5 clock = ~clock;

   base64_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   b64e_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .chars_owed  (chars_owed)
   );

   // The receiver stalls at random, cycle by cycle, at whatever rate the current phase sets.
   // A rate of zero gives a stretch with no back-pressure at all.
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // Offers one byte and waits until the block takes it. Idle cycles are inserted only before
   // the beat is presented, so a stalled beat never changes. After acceptance valid is left
   // high; the next call lowers it only if it decides to idle, which keeps a single update of
   // valid per clock edge.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {b, fin};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   // Sends whole messages of random content until the byte count reaches the given mark.
   // Lengths are mostly short so that every group phase ends a message often; now and then a
   // longer message runs through several complete groups.
   task automatic send_messages(input int upto);
      int len;
      while (bytes_sent < upto) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(16, 9) : $urandom_range(6, 1);
         for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(255)), i == len - 1);
         end
      end
   endtask

   // Holds the sender off until every character already owed has left the block. The extra
   // edge lets the checker count the byte accepted at the previous edge.
   task automatic drain_output();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_owed != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: a sender that rarely idles against a receiver that stalls half the time.
      send_gap_pct   = 6;
      recv_stall_pct = 52;
      for (int i = 0; i < 25; i++) begin
         send_byte(DIRECTED[i][8:1], DIRECTED[i][0]);
      end
      send_messages(60);

      // Let the block run completely dry once before carrying on.
      drain_output();

      // Phase two: the roles reversed, a hesitant sender and an eager receiver.
      send_gap_pct   = 52;
      recv_stall_pct = 6;
      send_messages(95);

      // Phase three: both sides at full speed.
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      send_messages(125);

      // Wait until nothing is owed, then give the block a little longer in case it emits a
      // stray character after its last expected one.
      drain_output();
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_base64_encoder: done, clean");
      end else begin
         $display("tb_base64_encoder: done, errors");
      end
      $finish;
   end

   // A hung handshake ends the run here; the bound is far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("tb_base64_encoder: done, errors");
      $finish;
   end

endmodule
